// File: hdl/ptq_pkg.sv
// Shared types and constants for the priority task queue.
package ptq_pkg;

  // Fixed field widths
  localparam int NUM_CLASSES = 3;
  localparam int CLS_W       = 2;
  localparam int IDENT_W     = 16;
  localparam int CNT_W       = 9;
  localparam int TOT_W       = 32;
  localparam int STATUS_W    = 3;
  localparam int POLICY_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  // Result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_PUSHED   = 3'd0;
  localparam status_t ST_DROPPED  = 3'd1;
  localparam status_t ST_REJECTED = 3'd2;
  localparam status_t ST_RETRY    = 3'd3;
  localparam status_t ST_POPPED   = 3'd4;
  localparam status_t ST_EMPTY    = 3'd5;

  // Full policy codes
  typedef logic [POLICY_W-1:0] policy_t;
  localparam policy_t POL_BLOCK  = 2'd0;
  localparam policy_t POL_DROP   = 2'd1;
  localparam policy_t POL_REJECT = 2'd2;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_POLICY = 2'd1;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] CAPACITY_RST = 9'd256;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;   // input transfer: decide and update queue state
    logic load;   // move the finished result into the output register
  } cmd_t;

endpackage

// File: hdl/ptq_if.sv
// Valid/ready channel interfaces for input, result and configuration.
interface ptq_in_if;
  import ptq_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [CLS_W-1:0]   priority_class;
  logic [IDENT_W-1:0] task_ident;
  logic               is_worker;
  modport source (output valid, operation, priority_class, task_ident, is_worker,
                  input ready);
  modport sink   (input valid, operation, priority_class, task_ident, is_worker,
                  output ready);
endinterface

interface ptq_out_if;
  import ptq_pkg::*;
  logic               valid;
  logic               ready;
  logic [STATUS_W-1:0] status;
  logic [IDENT_W-1:0] out_ident;
  logic [CNT_W-1:0]   occupancy;
  logic [CNT_W-1:0]   peak_occupancy;
  logic [TOT_W-1:0]   rejected_total;
  logic [TOT_W-1:0]   dropped_total;
  modport source (output valid, status, out_ident, occupancy, peak_occupancy,
                  rejected_total, dropped_total, input ready);
  modport sink   (input valid, status, out_ident, occupancy, peak_occupancy,
                  rejected_total, dropped_total, output ready);
endinterface

interface ptq_cfg_if;
  import ptq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/ptq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/ptq_ctrl.sv
// Controller: sequences one operation and the output register handshake.
module ptq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ptq_pkg::cmd_t cmd
);
  import ptq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign cmd.exec  = in_valid && in_ready_r;
  assign cmd.load  = (state_r == S_LOAD) && out_free;
  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.exec) begin
            state_r    <= S_LOAD;
            in_ready_r <= 1'b0;
          end
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_LOAD: begin
          // result register is free or drains on this edge
          if (out_free) begin
            state_r     <= S_IDLE;
            in_ready_r  <= 1'b1;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  a_load_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> !in_ready_r)
    else $error("input ready while a result is pending");

  a_exec_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> state_r == S_LOAD)
    else $error("transfer did not start a result");

endmodule

// File: hdl/ptq_dpath.sv
// Datapath: class queues, counters, configuration and the result register.
module ptq_dpath #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ptq_pkg::cmd_t                    cmd,
  input  logic                             in_operation,
  input  logic [ptq_pkg::CLS_W-1:0]        in_priority_class,
  input  logic [ptq_pkg::IDENT_W-1:0]      in_task_ident,
  input  logic                             in_is_worker,
  input  logic                             cfg_we,
  input  logic [ptq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptq_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [ptq_pkg::STATUS_W-1:0]     out_status,
  output logic [ptq_pkg::IDENT_W-1:0]      out_ident,
  output logic [ptq_pkg::CNT_W-1:0]        out_occupancy,
  output logic [ptq_pkg::CNT_W-1:0]        out_peak_occupancy,
  output logic [ptq_pkg::TOT_W-1:0]        out_rejected_total,
  output logic [ptq_pkg::TOT_W-1:0]        out_dropped_total
);
  import ptq_pkg::*;

  localparam int HEAD_W    = $clog2(QUEUE_DEPTH);
  localparam int SUM_W     = HEAD_W + 1;
  localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int BOUND_MAX = (QUEUE_DEPTH > CNT_MAX) ? CNT_MAX : QUEUE_DEPTH;

  // Configuration registers
  logic [CNT_W-1:0] cap_r;
  policy_t          policy_r;

  // Queue state
  logic [HEAD_W-1:0] head_r [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_r  [NUM_CLASSES];
  logic [CNT_W-1:0]  total_r;
  logic [CNT_W-1:0]  peak_r;
  logic [TOT_W-1:0]  rej_r;
  logic [TOT_W-1:0]  drop_r;

  // Pending result
  status_t status_r;
  logic    use_rd_r;

  // Result register
  status_t            res_status_r;
  logic [IDENT_W-1:0] res_ident_r;
  logic [CNT_W-1:0]   res_occ_r;
  logic [CNT_W-1:0]   res_peak_r;
  logic [TOT_W-1:0]   res_rej_r;
  logic [TOT_W-1:0]   res_drop_r;

  // Decision signals
  logic [CNT_W-1:0]  bound;
  logic              full;
  logic              is_pop;
  logic [CLS_W-1:0]  push_cls;
  logic [CLS_W-1:0]  pop_cls;
  logic [CLS_W-1:0]  victim;
  logic [CLS_W-1:0]  take_cls;
  logic              take_en;
  logic              push_en;
  status_t           status_nxt;
  logic [CNT_W-1:0]  total_nxt;
  logic [HEAD_W-1:0] take_head;
  logic [HEAD_W-1:0] push_head;
  logic [CNT_W-1:0]  push_cnt;
  logic [SUM_W-1:0]  tail_sum;
  logic [HEAD_W-1:0] tail_slot;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [IDENT_W-1:0] rd_data;

  function automatic logic [ADDR_W-1:0] class_base(input logic [CLS_W-1:0] c);
    logic [ADDR_W-1:0] b;
    b = '0;
    if (c == CLS_W'(1)) begin
      b = ADDR_W'(QUEUE_DEPTH);
    end else if (c == CLS_W'(2)) begin
      b = ADDR_W'(2 * QUEUE_DEPTH);
    end
    return b;
  endfunction

  function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
    logic [HEAD_W-1:0] r;
    r = (h == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : h + HEAD_W'(1);
    return r;
  endfunction

  // Effective capacity: zero acts as one, clipped to the ring depth or the counter maximum if smaller
  always_comb begin
    bound = cap_r;
    if (cap_r > CNT_W'(BOUND_MAX)) begin
      bound = CNT_W'(BOUND_MAX);
    end
    if (cap_r == '0) begin
      bound = CNT_W'(1);
    end
  end

  assign full     = total_r >= bound;
  assign is_pop   = (in_operation == OP_POP);
  assign push_cls = (in_priority_class == CLS_W'(3)) ? CLS_W'(2) : in_priority_class;

  // Pop scans from class 0; drop victim scans from class 2
  always_comb begin
    priority if (cnt_r[0] != '0) pop_cls = CLS_W'(0);
    else if (cnt_r[1] != '0)     pop_cls = CLS_W'(1);
    else                         pop_cls = CLS_W'(2);
    priority if (cnt_r[2] != '0) victim = CLS_W'(2);
    else if (cnt_r[1] != '0)     victim = CLS_W'(1);
    else                         victim = CLS_W'(0);
  end

  // Operation decision
  always_comb begin
    take_en    = 1'b0;
    push_en    = 1'b0;
    take_cls   = victim;
    status_nxt = ST_PUSHED;
    if (is_pop) begin
      take_cls   = pop_cls;
      take_en    = (total_r != '0);
      status_nxt = take_en ? ST_POPPED : ST_EMPTY;
    end else if (!full) begin
      push_en = 1'b1;
    end else if (policy_r == POL_DROP) begin
      take_en    = 1'b1;
      push_en    = 1'b1;
      status_nxt = ST_DROPPED;
    end else if (policy_r == POL_BLOCK && !in_is_worker) begin
      status_nxt = ST_RETRY;
    end else begin
      status_nxt = ST_REJECTED;
    end
  end

  always_comb begin
    total_nxt = total_r;
    if (take_en && !push_en) begin
      total_nxt = total_r - CNT_W'(1);
    end else if (push_en && !take_en) begin
      total_nxt = total_r + CNT_W'(1);
    end
  end

  // Ring addresses; the tail uses the pre-drop head and count
  always_comb begin
    take_head = head_r[0];
    push_head = head_r[0];
    push_cnt  = cnt_r[0];
    for (int i = 1; i < NUM_CLASSES; i++) begin
      if (take_cls == CLS_W'(i)) take_head = head_r[i];
      if (push_cls == CLS_W'(i)) begin
        push_head = head_r[i];
        push_cnt  = cnt_r[i];
      end
    end
    tail_sum  = {1'b0, push_head} + SUM_W'(push_cnt);
    tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);
    rd_addr   = class_base(take_cls) + ADDR_W'(take_head);
    wr_addr   = class_base(push_cls) + ADDR_W'(tail_slot);
  end

  ptq_ram #(
    .WIDTH (IDENT_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.exec && push_en),
    .waddr (wr_addr),
    .wdata (in_task_ident),
    .re    (cmd.exec && take_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAPACITY_RST;
      policy_r <= POL_REJECT;
    end else if (cfg_we) begin
      if (cfg_index == REG_CAPACITY) begin
        cap_r <= cfg_data;
      end else if (cfg_index == REG_FULL_POLICY) begin
        policy_r <= cfg_data[POLICY_W-1:0];
      end
    end
  end

  // Queue state update on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      total_r  <= '0;
      peak_r   <= '0;
      rej_r    <= '0;
      drop_r   <= '0;
      status_r <= ST_EMPTY;
      use_rd_r <= 1'b0;
    end else if (cmd.exec) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (take_en && take_cls == CLS_W'(i)) begin
          head_r[i] <= head_inc(head_r[i]);
        end
        if (take_en && take_cls == CLS_W'(i) && !(push_en && push_cls == CLS_W'(i))) begin
          cnt_r[i] <= cnt_r[i] - CNT_W'(1);
        end else if (push_en && push_cls == CLS_W'(i) &&
                     !(take_en && take_cls == CLS_W'(i))) begin
          cnt_r[i] <= cnt_r[i] + CNT_W'(1);
        end
      end
      total_r <= total_nxt;
      if (push_en && total_nxt > peak_r) begin
        peak_r <= total_nxt;
      end
      if (status_nxt == ST_REJECTED) begin
        rej_r <= rej_r + TOT_W'(1);
      end
      if (status_nxt == ST_DROPPED) begin
        drop_r <= drop_r + TOT_W'(1);
      end
      status_r <= status_nxt;
      use_rd_r <= take_en;
    end
  end

  // Output register, loaded once the read data is back
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r <= status_r;
      res_ident_r  <= use_rd_r ? rd_data : '0;
      res_occ_r    <= total_r;
      res_peak_r   <= peak_r;
      res_rej_r    <= rej_r;
      res_drop_r   <= drop_r;
    end
  end

  assign out_status         = res_status_r;
  assign out_ident          = res_ident_r;
  assign out_occupancy      = res_occ_r;
  assign out_peak_occupancy = res_peak_r;
  assign out_rejected_total = res_rej_r;
  assign out_dropped_total  = res_drop_r;

  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+2)'(total_r) == (CNT_W+2)'(cnt_r[0]) + (CNT_W+2)'(cnt_r[1]) +
                           (CNT_W+2)'(cnt_r[2]))
    else $error("total does not match class counts");

  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= peak_r)
    else $error("occupancy above peak");

  a_drop_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && status_nxt == ST_DROPPED |=> total_r == $past(total_r))
    else $error("drop-oldest changed occupancy");

endmodule

// File: hdl/priority_task_queue_backpressure.sv
// Top level of the three-class priority task queue with a full policy.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------
//  in_ch   | in  | valid / ready    | operation, priority_class, task_ident,
//          |     |                  | is_worker
//  out_ch  | out | valid / ready    | status, out_ident, occupancy, peak_occupancy,
//          |     |                  | rejected_total, dropped_total
//  cfg_ch  | in  | valid / ready=1  | index, data
//
// In each operation the transfer cycle decides and updates the class counts
// and writes or reads the shared task RAM; S_LOAD then takes the registered
// RAM read data into the output register once out_ch can take a result.
// No clearing pass after reset: the task RAM is only read where written.
// A result held by out_ch stalls the block after one further transfer.
module priority_task_queue_backpressure #(
  parameter int QUEUE_DEPTH = 256
) (
  input logic        clk,
  input logic        rst_n,
  ptq_in_if.sink     in_ch,
  ptq_out_if.source  out_ch,
  ptq_cfg_if.sink    cfg_ch
);
  import ptq_pkg::*;

  cmd_t cmd;

  // Configuration is always taken
  assign cfg_ch.ready = 1'b1;

  ptq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  ptq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_operation       (in_ch.operation),
    .in_priority_class  (in_ch.priority_class),
    .in_task_ident      (in_ch.task_ident),
    .in_is_worker       (in_ch.is_worker),
    .cfg_we             (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_status         (out_ch.status),
    .out_ident          (out_ch.out_ident),
    .out_occupancy      (out_ch.occupancy),
    .out_peak_occupancy (out_ch.peak_occupancy),
    .out_rejected_total (out_ch.rejected_total),
    .out_dropped_total  (out_ch.dropped_total)
  );

endmodule
